// ===== src/tkh_pkg.sv =====
package tkh_pkg;

   localparam int TKH_DEPTH = 64;

   // Configuration register indexes.
   localparam int CSR_IDXW = 1;
   localparam logic [CSR_IDXW-1:0] CSR_GRACE = 1'b0;
   localparam logic [CSR_IDXW-1:0] CSR_LIMIT = 1'b1;
   localparam int CSR_DATAW = 32;

   localparam logic [31:0] GRACE_RESET = 32'd64;
   localparam logic [6:0]  LIMIT_RESET = 7'd64;

   // Result status codes.
   localparam logic [2:0] ST_WAITING  = 3'd0;
   localparam logic [2:0] ST_MATCHED  = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_CONFLICT = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_EXPIRED  = 3'd5;

   typedef struct packed {
      logic hit_found;
      logic old_found;
      logic free_found;
   } scan_flags_type;

endpackage

// ===== src/tkh_scan.sv =====
module tkh_scan import tkh_pkg::*; #(
   parameter int DEPTH = TKH_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       step,
   input  logic [$clog2(DEPTH)-1:0]   idx,
   input  logic                       occ,
   input  logic [63:0]                ent_tick,
   input  logic [63:0]                req_tick,
   output scan_flags_type             flags,
   output logic [$clog2(DEPTH)-1:0]   hit_idx,
   output logic [$clog2(DEPTH)-1:0]   old_idx,
   output logic [63:0]                old_tick,
   output logic [$clog2(DEPTH)-1:0]   free_idx,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   scan_flags_type flags_ff, flags_in;
   logic [AW-1:0]  hit_ff, hit_in, old_ff, old_in, free_ff, free_in;
   logic [63:0]    otick_ff, otick_in;
   logic [CW-1:0]  count_ff, count_in;

   // One table entry is folded into the running oldest, hit, free and count per cycle in which step is high.
   always_comb begin
      flags_in = flags_ff;
      hit_in   = hit_ff;
      old_in   = old_ff;
      free_in  = free_ff;
      otick_in = otick_ff;
      count_in = count_ff;
      if (clear) begin
         flags_in = '0;
         count_in = '0;
      end else if (step) begin
         if (occ) begin
            count_in = count_ff + CW'(1);
            if (!flags_ff.old_found || (ent_tick < otick_ff)) begin
               flags_in.old_found = 1'b1;
               old_in   = idx;
               otick_in = ent_tick;
            end
            if (ent_tick == req_tick) begin
               flags_in.hit_found = 1'b1;
               hit_in = idx;
            end
         end else if (!flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_in = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         count_ff <= '0;
      end else begin
         flags_ff <= flags_in;
         count_ff <= count_in;
      end
      hit_ff   <= hit_in;
      old_ff   <= old_in;
      free_ff  <= free_in;
      otick_ff <= otick_in;
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_ff;
   assign old_idx  = old_ff;
   assign old_tick = otick_ff;
   assign free_idx = free_ff;
   assign count    = count_ff;

endmodule

// ===== src/tick_hash_pair_checker.sv =====
// Pairs local and remote state hashes by tick number.
// A word is offered on req_kind, req_tick, req_hash and req_current_tick and is
// taken at the rising edge where start is high and busy is low. The block then
// walks every table entry, one per cycle, through a single compare unit to find
// the oldest pending tick, a stored entry for the same tick, the lowest free
// slot and the occupancy. The EVAL state then reads the chosen entry's hashes
// and the FINISH state decides the outcome. Exactly one result word per request
// appears on the rsp_ ports for one cycle, marked by rsp_strobe, registered
// from the FINISH state. busy stays high from acceptance until the result is
// shown, so one word is in flight at a time, and a new word may be taken in the
// strobe cycle. The receiver cannot stall: each result is presented once and
// then dropped.
// The csr_ port writes grace_ticks (index 0) and pending_limit (index 1) at any
// edge with csr_we high; it should only be used while busy is low.
// Synchronous reset clears all valid bits, so the table is empty, and loads
// grace_ticks with 64 and pending_limit with 64.
module tick_hash_pair_checker import tkh_pkg::*; #(
   parameter int DEPTH = TKH_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [63:0]          req_tick,
   input  logic [63:0]          req_hash,
   input  logic [63:0]          req_current_tick,
   input  logic                 csr_we,
   input  logic [CSR_IDXW-1:0]  csr_index,
   input  logic [CSR_DATAW-1:0] csr_wdata,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic [63:0]          rsp_result_tick,
   output logic [63:0]          rsp_local_hash,
   output logic [63:0]          rsp_remote_hash
);

   localparam int AW   = $clog2(DEPTH);
   localparam int IW   = AW + 1;
   localparam int CW   = $clog2(DEPTH+1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_EVAL   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] grace_ff;
   logic [6:0]  limit_ff;

   // Captured request word.
   logic        kind_ff;
   logic [63:0] tick_ff, hash_ff, now_ff;

   // Scan sequencing: issue index into the tick memory, then the entry under compare.
   logic [IW-1:0] issue_ff, issue_in;
   logic          pvld_ff, pvld_in;
   logic [AW-1:0] pidx_ff;

   logic [DEPTH-1:0] lvalid_ff, rvalid_ff;

   logic [63:0] tick_mem  [DEPTH];
   logic [63:0] lhash_mem [DEPTH];
   logic [63:0] rhash_mem [DEPTH];
   logic [63:0] tick_rd_ff, lhash_rd_ff, rhash_rd_ff;

   scan_flags_type flags;
   logic [AW-1:0]  hit_idx, old_idx, free_idx;
   logic [63:0]    old_tick;
   logic [CW-1:0]  count;

   logic          accept, expire_now, expire_ff;
   logic [AW-1:0] sel_ff, hsel;

   logic          tick_we, lh_we, rh_we;
   logic [AW-1:0] waddr;
   logic          set_l, set_r, clr_sel;

   logic        strobe_ff, strobe_in;
   logic [2:0]  status_ff, status_in;
   logic [63:0] otick_ff, otick_in, olh_ff, olh_in, orh_ff, orh_in;

   logic        lv, rv, have, both, full;
   logic [63:0] lh, rh, stored;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= GRACE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRACE: grace_ff <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         tick_ff <= req_tick;
         hash_ff <= req_hash;
         now_ff  <= req_current_tick;
      end
   end

   tkh_scan #(.DEPTH(DEPTH)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept),
      .step     (pvld_ff),
      .idx      (pidx_ff),
      .occ      (lvalid_ff[pidx_ff] | rvalid_ff[pidx_ff]),
      .ent_tick (tick_rd_ff),
      .req_tick (tick_ff),
      .flags    (flags),
      .hit_idx  (hit_idx),
      .old_idx  (old_idx),
      .old_tick (old_tick),
      .free_idx (free_idx),
      .count    (count)
   );

   // Expiry needs the tick to be strictly past the oldest and beyond the grace window.
   assign expire_now = flags.old_found && (now_ff > old_tick) &&
                       ((now_ff - old_tick) > {32'b0, grace_ff});
   assign hsel = expire_now ? old_idx : hit_idx;

   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      pvld_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               issue_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < IW'(DEPTH)) begin
               pvld_in  = 1'b1;
               issue_in = issue_ff + IW'(1);
            end else if (!pvld_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL:   state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= pvld_in;
      end
      issue_ff <= issue_in;
      pidx_ff  <= issue_ff[AW-1:0];
      if (state_ff == S_EVAL) begin
         expire_ff <= expire_now;
         sel_ff    <= hsel;
      end
   end

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (tick_we) begin
         tick_mem[waddr] <= tick_ff;
      end
      tick_rd_ff <= tick_mem[issue_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (lh_we) begin
         lhash_mem[waddr] <= hash_ff;
      end
      lhash_rd_ff <= lhash_mem[hsel];
   end

   always_ff @(posedge clock) begin
      if (rh_we) begin
         rhash_mem[waddr] <= hash_ff;
      end
      rhash_rd_ff <= rhash_mem[hsel];
   end

   // Outcome of the request, decided in the last cycle from the selected entry.
   always_comb begin
      lv     = lvalid_ff[sel_ff];
      rv     = rvalid_ff[sel_ff];
      lh     = lhash_rd_ff;
      rh     = rhash_rd_ff;
      have   = kind_ff ? rv : lv;
      stored = kind_ff ? rh : lh;
      both   = kind_ff ? lv : rv;
      full   = !flags.free_found || (CMPW'(count) >= CMPW'(limit_ff));

      tick_we   = 1'b0;
      lh_we     = 1'b0;
      rh_we     = 1'b0;
      waddr     = sel_ff;
      set_l     = 1'b0;
      set_r     = 1'b0;
      clr_sel   = 1'b0;
      strobe_in = 1'b0;
      status_in = ST_WAITING;
      otick_in  = tick_ff;
      olh_in    = '0;
      orh_in    = '0;

      if (state_ff == S_FINISH) begin
         strobe_in = 1'b1;
         priority if (expire_ff) begin
            status_in = ST_EXPIRED;
            otick_in  = old_tick;
            olh_in    = lv ? lh : '0;
            orh_in    = rv ? rh : '0;
            clr_sel   = 1'b1;
         end else if (flags.hit_found) begin
            if (have) begin
               if (stored != hash_ff) begin
                  status_in = ST_CONFLICT;
                  olh_in    = kind_ff ? hash_ff : stored;
                  orh_in    = kind_ff ? stored : hash_ff;
               end
            end else if (both) begin
               // The other side is already here, so the pair completes and the slot frees.
               olh_in    = kind_ff ? lh : hash_ff;
               orh_in    = kind_ff ? hash_ff : rh;
               status_in = (olh_in == orh_in) ? ST_MATCHED : ST_MISMATCH;
               clr_sel   = 1'b1;
            end else begin
               lh_we = !kind_ff;
               rh_we = kind_ff;
               set_l = !kind_ff;
               set_r = kind_ff;
            end
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            waddr   = free_idx;
            tick_we = 1'b1;
            lh_we   = !kind_ff;
            rh_we   = kind_ff;
            set_l   = !kind_ff;
            set_r   = kind_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvalid_ff <= '0;
         rvalid_ff <= '0;
      end else begin
         if (clr_sel) begin
            lvalid_ff[sel_ff] <= 1'b0;
            rvalid_ff[sel_ff] <= 1'b0;
         end
         if (set_l) begin
            lvalid_ff[waddr] <= 1'b1;
         end
         if (set_r) begin
            rvalid_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      status_ff <= status_in;
      otick_ff  <= otick_in;
      olh_ff    <= olh_in;
      orh_ff    <= orh_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_tick = otick_ff;
   assign rsp_local_hash  = olh_ff;
   assign rsp_remote_hash = orh_ff;

`ifndef SYNTHESIS
   // A result is only shown once the sequencer has returned to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // A taken request always starts a table walk.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN))
      else $error("request taken without a scan");

   // Every walk ends with a result, strobed after the FINISH state that follows evaluation.
   a_eval_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ##2 rsp_strobe)
      else $error("evaluation without a result");

   // The occupancy counted by the walk never exceeds the table.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (CW'(count) <= CW'(DEPTH)))
      else $error("occupancy beyond table depth");
`endif

endmodule

// ===== sim/tb_tick_hash_pair_checker.sv =====
module tb_tick_hash_pair_checker;
   import tkh_pkg::*;

   // Observation sides, as carried on req_kind.
   localparam logic SIDE_LOCAL  = 1'b0;
   localparam logic SIDE_REMOTE = 1'b1;

   // The block answers a word once its table walk and evaluation are done.  The
   // cycle limit below covers about 1000 words at LATENCY plus sender gaps, many
   // times over.
   localparam int LATENCY     = TKH_DEPTH + 4;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] tick;
      logic [63:0] local_hash;
      logic [63:0] remote_hash;
   } pair_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic [63:0]          req_tick;
   logic [63:0]          req_hash;
   logic [63:0]          req_current_tick;
   logic                 csr_we;
   logic [CSR_IDXW-1:0]  csr_index;
   logic [CSR_DATAW-1:0] csr_wdata;
   logic                 rsp_strobe;
   logic [2:0]           rsp_status;
   logic [63:0]          rsp_result_tick;
   logic [63:0]          rsp_local_hash;
   logic [63:0]          rsp_remote_hash;

   tick_hash_pair_checker u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_tick(req_tick), .req_hash(req_hash),
      .req_current_tick(req_current_tick),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_result_tick(rsp_result_tick), .rsp_local_hash(rsp_local_hash),
      .rsp_remote_hash(rsp_remote_hash)
   );

   // Shadow copy of the pairing table and the two registers.
   logic [63:0] tbl_tick   [TKH_DEPTH];
   logic [63:0] tbl_lhash  [TKH_DEPTH];
   logic [63:0] tbl_rhash  [TKH_DEPTH];
   logic        tbl_lvalid [TKH_DEPTH];
   logic        tbl_rvalid [TKH_DEPTH];
   logic [31:0] grace_ticks;
   logic [6:0]  pending_limit;

   pair_result_type pending_results[$];
   int              error_count;
   int              cycle_count;
   int              send_idle_pct;

   // Ticks used by random tests are drawn from a sliding window so that
   // pairs, repeats, conflicts and expiry all happen regularly.
   logic [63:0] tick_base;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Predict the result of one observation and update the shadow table.
   function automatic pair_result_type predict_pairing(logic side, logic [63:0] tick,
                                                       logic [63:0] hash,
                                                       logic [63:0] now);
      pair_result_type r;
      int              oldest;
      int              hit;
      int              free_slot;
      int              count;
      logic [63:0]     ot;
      logic [63:0]     stored;
      logic            have;
      oldest = -1;
      hit = -1;
      free_slot = -1;
      count = 0;
      for (int i = 0; i < TKH_DEPTH; i++) begin
         if (tbl_lvalid[i] || tbl_rvalid[i]) begin
            count++;
            if (oldest < 0 || tbl_tick[i] < tbl_tick[oldest]) oldest = i;
            if (tbl_tick[i] == tick) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      r.tick = tick;
      r.local_hash = '0;
      r.remote_hash = '0;
      r.status = ST_WAITING;
      // Expire the oldest entry first; the observation itself is dropped.
      if (oldest >= 0) begin
         ot = tbl_tick[oldest];
         if (now > ot && (now - ot) > {32'd0, grace_ticks}) begin
            r.status = ST_EXPIRED;
            r.tick = ot;
            r.local_hash = tbl_lvalid[oldest] ? tbl_lhash[oldest] : 64'd0;
            r.remote_hash = tbl_rvalid[oldest] ? tbl_rhash[oldest] : 64'd0;
            tbl_lvalid[oldest] = 1'b0;
            tbl_rvalid[oldest] = 1'b0;
            return r;
         end
      end
      if (hit >= 0) begin
         have = (side == SIDE_REMOTE) ? tbl_rvalid[hit] : tbl_lvalid[hit];
         stored = (side == SIDE_REMOTE) ? tbl_rhash[hit] : tbl_lhash[hit];
         if (have) begin
            // A repeat of the same hash is harmless; a different one conflicts.
            if (stored != hash) begin
               r.status = ST_CONFLICT;
               r.local_hash = (side == SIDE_REMOTE) ? hash : stored;
               r.remote_hash = (side == SIDE_REMOTE) ? stored : hash;
            end
            return r;
         end
         if (side == SIDE_REMOTE) begin
            tbl_rhash[hit] = hash;
            tbl_rvalid[hit] = 1'b1;
         end else begin
            tbl_lhash[hit] = hash;
            tbl_lvalid[hit] = 1'b1;
         end
         if (tbl_lvalid[hit] && tbl_rvalid[hit]) begin
            r.local_hash = tbl_lhash[hit];
            r.remote_hash = tbl_rhash[hit];
            r.status = (r.local_hash == r.remote_hash) ? ST_MATCHED : ST_MISMATCH;
            tbl_lvalid[hit] = 1'b0;
            tbl_rvalid[hit] = 1'b0;
         end
         return r;
      end
      // A new tick needs room below both the limit and the table depth.
      if (count >= pending_limit || free_slot < 0) begin
         r.status = ST_FULL;
         return r;
      end
      tbl_tick[free_slot] = tick;
      if (side == SIDE_REMOTE) begin
         tbl_rhash[free_slot] = hash;
         tbl_rvalid[free_slot] = 1'b1;
      end else begin
         tbl_lhash[free_slot] = hash;
         tbl_lvalid[free_slot] = 1'b1;
      end
      return r;
   endfunction

   // Send one word: wait for the block to be free and hold start for the
   // accepting edge.  start is left high afterwards, which is harmless while
   // the block is busy; the next word's idle cycles or a drain lower it.
   task automatic send_word(logic side, logic [63:0] tick, logic [63:0] hash,
                            logic [63:0] now);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= side;
      req_tick <= tick;
      req_hash <= hash;
      req_current_tick <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_pairing(side, tick, hash, now));
   endtask

   // Wait until every expected word has come back, then a little longer.
   task automatic drain_results();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_results.size() != 0 && guard < 100 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_csr(logic [CSR_IDXW-1:0] idx, logic [31:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GRACE) grace_ticks = value;
      else pending_limit = value[6:0];
   endtask

   // Each strobed word is compared with the oldest prediction.
   always @(posedge clock) begin
      pair_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word status=%0d tick=%h", $realtime,
                     rsp_status, rsp_result_tick);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_status);
               error_count++;
            end
            if (rsp_result_tick !== want.tick) begin
               $display("%0t: result_tick expected %h actual %h", $realtime,
                        want.tick, rsp_result_tick);
               error_count++;
            end
            if (rsp_local_hash !== want.local_hash) begin
               $display("%0t: local_hash expected %h actual %h", $realtime,
                        want.local_hash, rsp_local_hash);
               error_count++;
            end
            if (rsp_remote_hash !== want.remote_hash) begin
               $display("%0t: remote_hash expected %h actual %h", $realtime,
                        want.remote_hash, rsp_remote_hash);
               error_count++;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Directed cases: pairing both ways, repeats, conflicts on each side,
   // expiry, a full table, and the extremes of every field.
   task automatic test_directed();
      logic [63:0] ones;
      ones = '1;
      send_word(SIDE_LOCAL, 64'd10, 64'hAAAA, 64'd10);
      send_word(SIDE_LOCAL, 64'd10, 64'hAAAA, 64'd10);   // same hash again
      send_word(SIDE_LOCAL, 64'd10, 64'hBBBB, 64'd10);   // local conflict
      send_word(SIDE_REMOTE, 64'd10, 64'hAAAA, 64'd10);  // matched
      send_word(SIDE_REMOTE, 64'd11, 64'h1234, 64'd11);
      send_word(SIDE_REMOTE, 64'd11, 64'h4321, 64'd11);  // remote conflict
      send_word(SIDE_LOCAL, 64'd11, 64'h5555, 64'd11);   // mismatch
      send_word(SIDE_LOCAL, ones, ones, ones);
      send_word(SIDE_REMOTE, ones, ones, ones);          // matched at all ones
      send_word(SIDE_REMOTE, 64'd0, 64'd0, 64'd0);
      send_word(SIDE_LOCAL, 64'd0, ones, 64'd0);         // mismatch at zero tick
      send_word(SIDE_LOCAL, 64'd5, 64'h77, 64'd5);
      send_word(SIDE_LOCAL, 64'd6, 64'h88, 64'd69);      // exactly at grace
      send_word(SIDE_REMOTE, 64'd6, 64'h99, 64'd70);     // tick 5 expires
      send_word(SIDE_REMOTE, 64'd6, 64'h88, ones);       // tick 6 expires
      send_word(SIDE_LOCAL, 64'd9, 64'h1, ones);         // stored, table empty
      send_word(SIDE_LOCAL, 64'd7, 64'h1, 64'd0);        // 9 not stale
      write_csr(CSR_LIMIT, 32'd2);
      send_word(SIDE_REMOTE, 64'd8, 64'h2, 64'd0);       // full
      send_word(SIDE_REMOTE, 64'd7, 64'h1, 64'd0);       // completes, not full
      write_csr(CSR_GRACE, 32'd0);
      send_word(SIDE_LOCAL, 64'd3, 64'h3, 64'd10);       // tick 9 expires
      write_csr(CSR_GRACE, 32'hFFFF_FFFF);
      send_word(SIDE_LOCAL, 64'd4, 64'h3, ones);         // huge grace, no expiry
      send_word(SIDE_REMOTE, 64'd4, 64'h3, ones);
      drain_results();
   endtask

   // Random traffic around a moving tick window.  Most words complete or
   // repeat nearby ticks; current_tick mostly trails the window.
   task automatic run_random(int words);
      logic [63:0] t;
      logic [63:0] h;
      logic [63:0] now;
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(9, 0) == 0) tick_base += $urandom_range(8, 1);
         t = tick_base + $urandom_range(15, 0);
         h = ($urandom_range(3, 0) == 0) ? rand64() : {60'd0, 4'(t[3:0])};
         case ($urandom_range(9, 0))
            0: now = rand64();
            1: now = t + $urandom_range(200, 0);
            default: now = tick_base + $urandom_range(20, 0);
         endcase
         if ($urandom_range(19, 0) == 0) t = rand64();
         send_word(1'($urandom_range(1, 0)), t, h, now);
      end
   endtask

   task automatic test_random_phases();
      int settings[4];
      settings = '{32'd0, 32'd4, 32'd16, 32'd64};
      foreach (settings[k]) begin
         write_csr(CSR_GRACE, settings[k] + $urandom_range(3, 0));
         write_csr(CSR_LIMIT, (k == 3) ? 32'd127 : 32'($urandom_range(64, 0)));
         send_idle_pct = (k % 2 == 0) ? 15 : 50;
         if (k == 3) send_idle_pct = 0;
         run_random(160);
      end
   endtask

   // Fill the whole table with unpaired ticks so depth, not the limit, refuses.
   task automatic test_depth_saturation();
      write_csr(CSR_GRACE, 32'hFFFF_FFFF);
      write_csr(CSR_LIMIT, 32'd127);
      for (int i = 0; i < TKH_DEPTH + 2; i++)
         send_word(SIDE_LOCAL, 64'd1000 + i, 64'(i), 64'd1000);
      write_csr(CSR_LIMIT, 32'd0);
      send_word(SIDE_REMOTE, 64'd1000, 64'd0, 64'd1000);  // pair still completes
      send_word(SIDE_REMOTE, 64'd5000, 64'd0, 64'd1000);  // full at limit zero
      write_csr(CSR_GRACE, 32'd0);
      for (int i = 0; i < TKH_DEPTH; i++)
         send_word(SIDE_REMOTE, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      tick_base = 64'd100;
      grace_ticks = GRACE_RESET;
      pending_limit = LIMIT_RESET;
      for (int i = 0; i < TKH_DEPTH; i++) begin
         tbl_lvalid[i] = 1'b0;
         tbl_rvalid[i] = 1'b0;
      end
      reset = 1'b1;
      start = 1'b0;
      req_kind = 1'b0;
      req_tick = '0;
      req_hash = '0;
      req_current_tick = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      test_directed();
      test_random_phases();
      test_depth_saturation();
      drain_results();

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tkh_pkg.sv
src/tkh_scan.sv
src/tick_hash_pair_checker.sv
sim/tb_tick_hash_pair_checker.sv
